/* rtl/core/cbpg_pkg.sv */
// shared constants, types and command/status structs of the bezier point generator
package cbpg_pkg;

    localparam int COORD_W   = 16;
    localparam int T_FRAC    = 16;
    localparam int T_W       = T_FRAC + 1;
    localparam int N_CTRL    = 4;
    localparam int N_AXIS    = 3;
    localparam int IN_W      = COORD_W * N_CTRL * N_AXIS;
    localparam int OUT_W     = COORD_W * N_AXIS;
    localparam int STEP_W    = 16;
    localparam int ADDR_W    = 2;

    localparam logic [T_W-1:0]    T_ONE      = T_W'(1 << T_FRAC);
    localparam int                MIN_STEP_I = ((1 << T_FRAC) + 62) / 63;
    localparam logic [STEP_W-1:0] MIN_STEP   = STEP_W'(MIN_STEP_I);
    localparam logic [STEP_W-1:0] T_STEP_RST = 16'd1639;

    localparam logic [ADDR_W-1:0] REG_T_STEP = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic load;
        logic issue;
    } t_cmd;

    typedef struct packed {
        logic adv;
        logic last_issue;
        logic busy;
    } t_stat;

endpackage

/* rtl/core/cubic_bezier_point_generator.sv */
// top level: stream ports, t_step register on the apb port, controller and datapath
//
// Cubic Bezier point generator.
// Slave stream: one request carries the four 3D control points of a curve
// (signed Q8.8). The block then emits the curve points on the master stream
// for t = 0, t_step, 2*t_step, ... while t <= 1.0, one point per cycle while the receiver is ready, and
// sets tlast on the final point. t_step (Q0.16, register 0 on the apb port,
// reset 1639) is raised to 1041 when smaller, so a curve has at most 63 points.
// The points follow back to back through a six-stage weight and sum
// pipeline; the next request is taken only once the last point of the
// previous curve has left.
// A stalled receiver freezes the whole pipeline; the point on the output
// holds until taken and nothing is dropped.
// Reset (synchronous, active low) empties the pipeline, returns the
// controller to idle and sets t_step to 1639.
// t_step should be written only while no curve is in progress.
module cubic_bezier_point_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_x, start_y, start_z, pull_one_x, pull_one_y, pull_one_z,
    // pull_two_x, pull_two_y, pull_two_z, finish_x, finish_y, finish_z
    input  logic [cbpg_pkg::IN_W-1:0]     s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // point_x, point_y, point_z
    output logic [cbpg_pkg::OUT_W-1:0]    m_axis_tdata,
    output logic                          m_axis_tlast,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cbpg_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import cbpg_pkg::*;

    logic [STEP_W-1:0] r_t_step;
    t_cmd              cmd;
    t_stat             stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_step <= T_STEP_RST;
        end else if (psel && penable && pwrite && pready && paddr == REG_T_STEP) begin
            r_t_step <= pwdata[STEP_W-1:0];
        end
    end

    assign prdata = (paddr == REG_T_STEP) ? {{(32-STEP_W){1'b0}}, r_t_step} : '0;

    cbpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cbpg_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_points    (s_axis_tdata),
        .i_t_step    (r_t_step),
        .i_out_ready (m_axis_tready),
        .o_stat      (stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

/* rtl/core/cbpg_ctrl.sv */
// controller state machine: takes a curve request, issues t values, waits for drain
module cbpg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  cbpg_pkg::t_stat i_stat,
    output cbpg_pkg::t_cmd  o_cmd
);
    import cbpg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_cmd.load  = 1'b0;
        o_cmd.issue = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.issue = 1'b1;
                if (i_stat.adv && i_stat.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/cbpg_dpath.sv */
// datapath: t stepping, bernstein weight pipeline, weighted sums and output register
module cbpg_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cbpg_pkg::t_cmd               i_cmd,
    input  logic [cbpg_pkg::IN_W-1:0]    i_points,
    input  logic [cbpg_pkg::STEP_W-1:0]  i_t_step,
    input  logic                         i_out_ready,
    output cbpg_pkg::t_stat              o_stat,
    output logic                         o_out_valid,
    output logic [cbpg_pkg::OUT_W-1:0]   o_out_data,
    output logic                         o_out_last
);
    import cbpg_pkg::*;

    localparam int PR_W  = T_W + 1 + COORD_W;
    localparam int SUM_W = PR_W + 2;
    localparam int SH_W  = SUM_W - T_FRAC;

    // q1.16 product rounded half up
    function automatic logic [T_W-1:0] qmul(input logic [T_W-1:0] a, input logic [T_W-1:0] b);
        logic [2*T_W-1:0] p;
        p = {{T_W{1'b0}}, a} * {{T_W{1'b0}}, b} + (2*T_W)'(1 << (T_FRAC - 1));
        return p[T_FRAC +: T_W];
    endfunction

    function automatic logic [T_W-1:0] times3(input logic [T_W-1:0] a);
        logic [T_W:0] s;
        s = {a, 1'b0} + {1'b0, a};
        return s[T_W-1:0];
    endfunction

    logic signed [COORD_W-1:0] r_pts [N_CTRL*N_AXIS];
    logic [STEP_W-1:0]         r_step;
    logic [T_W-1:0]            r_t;
    logic [T_W:0]              t_nxt;
    logic                      adv;
    logic                      last_issue;

    logic                      r_v1, r_v2, r_v3, r_v4, r_v5, r_ov;
    logic                      r_l1, r_l2, r_l3, r_l4, r_l5, r_ol;
    logic [T_W-1:0]            r1_t, r1_ct;
    logic [T_W-1:0]            r2_t, r2_ct, r2_t2, r2_ct2;
    logic [T_W-1:0]            r3_w0, r3_w3, r3_q1, r3_q2;
    logic [T_W-1:0]            r4_w [N_CTRL];
    logic signed [PR_W-1:0]    r5_pr [N_AXIS][N_CTRL];
    logic [OUT_W-1:0]          r_odata;
    logic [OUT_W-1:0]          n_odata;

    assign adv        = !r_ov || i_out_ready;
    assign t_nxt      = {1'b0, r_t} + {2'b0, r_step};
    assign last_issue = t_nxt > {1'b0, T_ONE};

    assign o_stat.adv        = adv;
    assign o_stat.last_issue = last_issue;
    assign o_stat.busy       = r_v1 | r_v2 | r_v3 | r_v4 | r_v5 | r_ov;

    // curve setup and t stepping
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int i = 0; i < N_CTRL*N_AXIS; i++) begin
                r_pts[i] <= i_points[i*COORD_W +: COORD_W];
            end
            r_step <= (i_t_step < MIN_STEP) ? MIN_STEP : i_t_step;
            r_t    <= '0;
        end else if (i_cmd.issue && adv) begin
            r_t <= t_nxt[T_W-1:0];
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_ov <= r_v5;
        end
    end

    // weighted sum per axis, round half up, saturate
    always_comb begin
        logic signed [SUM_W-1:0] s;
        logic signed [SH_W-1:0]  sh;
        n_odata = '0;
        for (int c = 0; c < N_AXIS; c++) begin
            s = SUM_W'(1 << (T_FRAC - 1));
            for (int k = 0; k < N_CTRL; k++) begin
                s = s + SUM_W'(r5_pr[c][k]);
            end
            sh = s[SUM_W-1:T_FRAC];
            if (sh > SH_W'((1 << (COORD_W - 1)) - 1)) begin
                n_odata[c*COORD_W +: COORD_W] = {1'b0, {(COORD_W-1){1'b1}}};
            end else if (sh < -SH_W'(1 << (COORD_W - 1))) begin
                n_odata[c*COORD_W +: COORD_W] = {1'b1, {(COORD_W-1){1'b0}}};
            end else begin
                n_odata[c*COORD_W +: COORD_W] = sh[COORD_W-1:0];
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_t   <= r_t;
            r1_ct  <= T_ONE - r_t;
            r_l1   <= last_issue;

            r2_t   <= r1_t;
            r2_ct  <= r1_ct;
            r2_t2  <= qmul(r1_t, r1_t);
            r2_ct2 <= qmul(r1_ct, r1_ct);
            r_l2   <= r_l1;

            r3_w0  <= qmul(r2_ct2, r2_ct);
            r3_w3  <= qmul(r2_t2, r2_t);
            r3_q1  <= qmul(r2_t, r2_ct2);
            r3_q2  <= qmul(r2_t2, r2_ct);
            r_l3   <= r_l2;

            r4_w[0] <= r3_w0;
            r4_w[1] <= times3(r3_q1);
            r4_w[2] <= times3(r3_q2);
            r4_w[3] <= r3_w3;
            r_l4    <= r_l3;

            for (int c = 0; c < N_AXIS; c++) begin
                for (int k = 0; k < N_CTRL; k++) begin
                    r5_pr[c][k] <= $signed({1'b0, r4_w[k]}) * r_pts[k*N_AXIS + c];
                end
            end
            r_l5    <= r_l4;

            r_odata <= n_odata;
            r_ol    <= r_l5;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_odata;
    assign o_out_last  = r_ol;

endmodule

/* rtl/core/cbpg_chk.sv */
// port-level checker for the bezier point generator, bound to the top level
module cbpg_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [cbpg_pkg::OUT_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tlast
);

    // a new curve is only taken once the previous one has fully left
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while points still pending");

    // one curve at a time
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a request was taken");

    // nothing trails the last point of a curve
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
        else $error("output valid after the last point");

    // stalled output holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled output changed");

endmodule

bind cubic_bezier_point_generator cbpg_chk u_cbpg_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
